[sv/sbcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcs_pkg - shared types and constants of the swept box side test
// Widths of coordinates, distances and Q.16 times, plus the job record that
// travels from the classifier to the divider back end.
// ----------------------------------------------------------------------------
package sbcs_pkg;

    localparam int COORD_BITS     = 24;
    localparam int TIME_FRAC_BITS = 16;

    // exact difference of two coordinates
    localparam int DIST_W = COORD_BITS + 1;
    // magnitude of such a difference
    localparam int MAG_W  = COORD_BITS;
    // quotient magnitude bits below the saturation point
    localparam int QMAG   = TIME_FRAC_BITS + 1;
    // saturated signed time, about [-2, 2)
    localparam int TIME_W = TIME_FRAC_BITS + 2;
    // partial remainder of the restoring divider
    localparam int REM_W  = MAG_W + TIME_FRAC_BITS + 1;
    // divider latency: setup, one stage per quotient bit, format
    localparam int DIV_LAT = QMAG + 2;

    localparam int MQ_DEPTH = 4;
    localparam int MQ_AW    = $clog2(MQ_DEPTH);

    localparam logic signed [TIME_W-1:0] TIME_ONE = TIME_W'(1) << TIME_FRAC_BITS;
    localparam logic signed [TIME_W-1:0] TIME_MAX = ~(TIME_W'(1) << (TIME_W - 1));
    localparam logic signed [TIME_W-1:0] TIME_MIN = TIME_W'(1) << (TIME_W - 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIST_W-1:0]     t_dist;
    typedef logic signed [TIME_W-1:0]     t_time;

    typedef enum logic [2:0] {
        SIDE_NONE   = 3'd0,
        SIDE_LEFT   = 3'd1,
        SIDE_RIGHT  = 3'd2,
        SIDE_TOP    = 3'd3,
        SIDE_BOTTOM = 3'd4
    } t_side;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_STATIC,
        KIND_SWEPT
    } t_kind;

    // control carried alongside the divisions
    typedef struct packed {
        t_kind kind_x;
        t_kind kind_y;
        logic  side_hi_x;
        logic  side_hi_y;
        logic  x_wins;
    } t_band;

    typedef struct packed {
        t_band band;
        t_dist de_x;
        t_dist dx_x;
        t_dist v_x;
        t_dist de_y;
        t_dist dx_y;
        t_dist v_y;
    } t_job;

endpackage

[sv/swept_box_collision_side.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_box_collision_side - side on which box A meets box B
// Classifies each axis as static or swept, divides entry and exit distances
// by the relative step in pipelined dividers and resolves one side per beat.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | i_push / o_full    | box edges of A and B, steps of A and B
//  result   | o_empty / i_pop    | o_contact_side (none/left/right/top/bottom)
//
//  One beat per cycle is accepted and one result per cycle delivered as long as the receiver keeps popping.
//  From accept to result a beat passes the input register, the job queue,
//  the divider setup stage, one stage per quotient bit, the format stage
//  and the two-entry result queue; most of that path is the divider pipeline.
//  Reset (synchronous, active low) empties every queue and pipe at once.
//  A stalled result freezes the divider pipe; the 4-deep job queue and the
//  input register keep taking beats until they too fill.
// ----------------------------------------------------------------------------
module swept_box_collision_side (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  sbcs_pkg::t_coord i_a_left,
    input  sbcs_pkg::t_coord i_a_right,
    input  sbcs_pkg::t_coord i_a_top,
    input  sbcs_pkg::t_coord i_a_bottom,
    input  sbcs_pkg::t_coord i_b_left,
    input  sbcs_pkg::t_coord i_b_right,
    input  sbcs_pkg::t_coord i_b_top,
    input  sbcs_pkg::t_coord i_b_bottom,
    input  sbcs_pkg::t_coord i_a_step_x,
    input  sbcs_pkg::t_coord i_a_step_y,
    input  sbcs_pkg::t_coord i_b_step_x,
    input  sbcs_pkg::t_coord i_b_step_y,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [2:0]       o_contact_side
);
    import sbcs_pkg::*;

    logic  f_vld, q_full, q_empty, q_pop;
    t_job  f_job, q_job;
    t_side side;

    // classify and hold one beat
    sbcs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_a_left   (i_a_left),
        .i_a_right  (i_a_right),
        .i_a_top    (i_a_top),
        .i_a_bottom (i_a_bottom),
        .i_b_left   (i_b_left),
        .i_b_right  (i_b_right),
        .i_b_top    (i_b_top),
        .i_b_bottom (i_b_bottom),
        .i_a_step_x (i_a_step_x),
        .i_a_step_y (i_a_step_y),
        .i_b_step_x (i_b_step_x),
        .i_b_step_y (i_b_step_y),
        .o_job_vld  (f_vld),
        .i_job_rdy  (!q_full),
        .o_job      (f_job)
    );

    // decouple classifier from divider pipe
    sbcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_vld),
        .i_data  (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_job)
    );

    // divide, resolve the side, queue the result
    sbcs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_vld (!q_empty),
        .o_job_pop (q_pop),
        .i_job     (q_job),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_side    (side)
    );

    assign o_contact_side = side;

endmodule

[sv/sbcs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcs_front - input stage and per-axis classifier
// Registers one beat, works out relative steps, static or swept per axis,
// sides and the static depth winner, and offers the job to the queue.
// ----------------------------------------------------------------------------
module sbcs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  sbcs_pkg::t_coord  i_a_left,
    input  sbcs_pkg::t_coord  i_a_right,
    input  sbcs_pkg::t_coord  i_a_top,
    input  sbcs_pkg::t_coord  i_a_bottom,
    input  sbcs_pkg::t_coord  i_b_left,
    input  sbcs_pkg::t_coord  i_b_right,
    input  sbcs_pkg::t_coord  i_b_top,
    input  sbcs_pkg::t_coord  i_b_bottom,
    input  sbcs_pkg::t_coord  i_a_step_x,
    input  sbcs_pkg::t_coord  i_a_step_y,
    input  sbcs_pkg::t_coord  i_b_step_x,
    input  sbcs_pkg::t_coord  i_b_step_y,
    output logic              o_job_vld,
    input  logic              i_job_rdy,
    output sbcs_pkg::t_job    o_job
);
    import sbcs_pkg::*;

    typedef logic signed [DIST_W:0] t_wide;

    typedef struct packed {
        t_kind kind;
        logic  side_hi;
        t_dist depth;
        t_dist de;
        t_dist dx;
    } t_cls;

    function automatic t_cls classify(input t_coord a_lo, input t_coord a_hi,
                                      input t_coord b_lo, input t_coord b_hi,
                                      input t_dist v);
        t_cls  r;
        t_wide alo, ahi, blo, bhi, lim, de, dx;
        logic  low;
        alo = t_wide'(a_lo);
        ahi = t_wide'(a_hi);
        blo = t_wide'(b_lo);
        bhi = t_wide'(b_hi);
        lim = blo - (ahi - alo);
        r   = '0;
        r.kind = KIND_NONE;
        if (v == '0 || (ahi >= blo && alo <= bhi)) begin
            if (alo <= bhi && alo >= lim) begin
                low       = (alo <= blo);
                r.kind    = KIND_STATIC;
                r.side_hi = !low;
                r.depth   = low ? DIST_W'(ahi - blo) : DIST_W'(bhi - alo);
            end
        end else begin
            de = blo - ahi;
            dx = bhi - alo;
            r.kind = KIND_SWEPT;
            if (v < 0) begin
                r.de = DIST_W'(dx);
                r.dx = DIST_W'(de);
            end else begin
                r.de = DIST_W'(de);
                r.dx = DIST_W'(dx);
            end
            r.side_hi = r.de < 0;
        end
        return r;
    endfunction

    logic  r_vld;
    t_job  r_job;
    t_job  n_job;
    t_dist vx, vy;
    t_cls  cx, cy;

    assign o_full    = r_vld && !i_job_rdy;
    assign o_job_vld = r_vld;
    assign o_job     = r_job;

    always_comb begin
        vx = t_dist'(i_a_step_x) - t_dist'(i_b_step_x);
        vy = t_dist'(i_a_step_y) - t_dist'(i_b_step_y);
        cx = classify(i_a_left, i_a_right, i_b_left, i_b_right, vx);
        cy = classify(i_a_bottom, i_a_top, i_b_bottom, i_b_top, vy);
        n_job.band.kind_x    = cx.kind;
        n_job.band.kind_y    = cy.kind;
        n_job.band.side_hi_x = cx.side_hi;
        n_job.band.side_hi_y = cy.side_hi;
        n_job.band.x_wins    = cx.depth <= cy.depth;
        n_job.de_x = cx.de;
        n_job.dx_x = cx.dx;
        n_job.v_x  = vx;
        n_job.de_y = cy.de;
        n_job.dx_y = cy.dx;
        n_job.v_y  = vy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_full) begin
            r_vld <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_full && i_push) begin
            r_job <= n_job;
        end
    end

endmodule

[sv/sbcs_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcs_queue - short job queue between classifier and back end
// Small register FIFO of jobs with one read port.
// ----------------------------------------------------------------------------
module sbcs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sbcs_pkg::t_job  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output sbcs_pkg::t_job  o_data
);
    import sbcs_pkg::*;

    t_job             r_mem [MQ_DEPTH];
    logic [MQ_AW:0]   r_wp, r_rp;
    logic             do_push, do_pop;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[MQ_AW] != r_rp[MQ_AW]) &&
                     (r_wp[MQ_AW-1:0] == r_rp[MQ_AW-1:0]);
    assign o_data  = r_mem[r_rp[MQ_AW-1:0]];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp[MQ_AW-1:0]] <= i_data;
        end
    end

endmodule

[sv/sbcs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcs_div - pipelined saturating time divider
// Restoring division of distance * 2^TIME_FRAC_BITS by step, one quotient
// bit per stage, truncated toward zero and clamped to the time range.
// ----------------------------------------------------------------------------
module sbcs_div (
    input  logic           i_clk,
    input  logic           i_en,
    input  sbcs_pkg::t_dist i_d,
    input  sbcs_pkg::t_dist i_v,
    output sbcs_pkg::t_time o_time
);
    import sbcs_pkg::*;

    logic [REM_W-1:0] r_rem [QMAG+1];
    logic [REM_W-1:0] r_dv  [QMAG+1];
    logic [QMAG-1:0]  r_q   [QMAG+1];
    logic             r_neg [QMAG+1];
    logic             r_ovf [QMAG+1];
    logic [REM_W-1:0] n_rem [QMAG+1];
    logic [QMAG-1:0]  n_q   [QMAG+1];
    t_time            r_time;
    t_dist            abs_d, abs_v;
    logic [MAG_W-1:0] mag_d, mag_v;
    t_time            mag_t;

    always_comb begin
        abs_d = (i_d < 0) ? -i_d : i_d;
        abs_v = (i_v < 0) ? -i_v : i_v;
        mag_d = abs_d[MAG_W-1:0];
        mag_v = abs_v[MAG_W-1:0];
    end

    // one restoring step per stage
    always_comb begin
        n_rem[0] = r_rem[0];
        n_q[0]   = r_q[0];
        for (int k = 1; k <= QMAG; k++) begin
            if (r_rem[k-1] >= (r_dv[k-1] << (QMAG - k))) begin
                n_rem[k] = r_rem[k-1] - (r_dv[k-1] << (QMAG - k));
                n_q[k]   = r_q[k-1] | (QMAG'(1) << (QMAG - k));
            end else begin
                n_rem[k] = r_rem[k-1];
                n_q[k]   = r_q[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= REM_W'(mag_d) << TIME_FRAC_BITS;
            r_dv[0]  <= REM_W'(mag_v);
            r_q[0]   <= '0;
            r_neg[0] <= (i_d < 0) != (i_v < 0);
            // quotient at or above 2.0 clamps
            r_ovf[0] <= {1'b0, mag_d} >= {mag_v, 1'b0};
            for (int k = 1; k <= QMAG; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_dv[k]  <= r_dv[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign mag_t = {1'b0, r_q[QMAG]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ovf[QMAG]) begin
                r_time <= r_neg[QMAG] ? TIME_MIN : TIME_MAX;
            end else begin
                r_time <= r_neg[QMAG] ? -mag_t : mag_t;
            end
        end
    end

    assign o_time = r_time;

endmodule

[sv/sbcs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcs_back - divider pipeline, side resolution and result queue
// Four dividers give entry and exit times per axis; the last stage picks the
// side and writes it into a two-entry result queue.
// ----------------------------------------------------------------------------
module sbcs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_vld,
    output logic            o_job_pop,
    input  sbcs_pkg::t_job  i_job,
    output logic            o_empty,
    input  logic            i_pop,
    output sbcs_pkg::t_side o_side
);
    import sbcs_pkg::*;

    logic  r_vld  [DIV_LAT];
    t_band r_band [DIV_LAT];
    logic  adv;
    t_time tex, txx, tey, tyx;
    t_time ent, ext;
    t_side sx, sy, n_side;
    t_band b;

    t_side     r_oq [2];
    logic [1:0] r_oq_cnt;
    logic      r_oq_wp, r_oq_rp;
    logic      oq_full, oq_push, oq_pop;

    function automatic logic hit(input t_time e, input t_time x);
        return (e < x) && (e > 0) && (e < TIME_ONE);
    endfunction

    // freeze the whole pipe only when a result has nowhere to go
    assign oq_full   = (r_oq_cnt == 2'd2);
    assign adv       = !r_vld[DIV_LAT-1] || !oq_full;
    assign o_job_pop = adv && i_job_vld;

    sbcs_div u_div_xe (.i_clk(i_clk), .i_en(adv), .i_d(i_job.de_x), .i_v(i_job.v_x),
                       .o_time(tex));
    sbcs_div u_div_xx (.i_clk(i_clk), .i_en(adv), .i_d(i_job.dx_x), .i_v(i_job.v_x),
                       .o_time(txx));
    sbcs_div u_div_ye (.i_clk(i_clk), .i_en(adv), .i_d(i_job.de_y), .i_v(i_job.v_y),
                       .o_time(tey));
    sbcs_div u_div_yx (.i_clk(i_clk), .i_en(adv), .i_d(i_job.dx_y), .i_v(i_job.v_y),
                       .o_time(tyx));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) r_vld[k] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_job_vld;
            for (int k = 1; k < DIV_LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_band[0] <= i_job.band;
            for (int k = 1; k < DIV_LAT; k++) r_band[k] <= r_band[k-1];
        end
    end

    always_comb begin
        b   = r_band[DIV_LAT-1];
        sx  = b.side_hi_x ? SIDE_RIGHT : SIDE_LEFT;
        sy  = b.side_hi_y ? SIDE_TOP : SIDE_BOTTOM;
        ent = (tex > tey) ? tex : tey;
        ext = (txx < tyx) ? txx : tyx;
        n_side = SIDE_NONE;
        if (b.kind_x == KIND_NONE || b.kind_y == KIND_NONE) begin
            n_side = SIDE_NONE;
        end else if (b.kind_x == KIND_STATIC && b.kind_y == KIND_STATIC) begin
            n_side = b.x_wins ? sx : sy;
        end else if (b.kind_x == KIND_SWEPT && b.kind_y == KIND_STATIC) begin
            if (hit(tex, txx)) n_side = sx;
        end else if (b.kind_x == KIND_STATIC && b.kind_y == KIND_SWEPT) begin
            if (hit(tey, tyx)) n_side = sy;
        end else begin
            if (hit(ent, ext)) n_side = (tex > tey) ? sx : sy;
        end
    end

    assign oq_push = adv && r_vld[DIV_LAT-1];
    assign oq_pop  = i_pop && (r_oq_cnt != 2'd0);
    assign o_empty = (r_oq_cnt == 2'd0);
    assign o_side  = r_oq[r_oq_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_cnt <= 2'd0;
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
        end else begin
            if (oq_push) r_oq_wp <= !r_oq_wp;
            if (oq_pop)  r_oq_rp <= !r_oq_rp;
            case ({oq_push, oq_pop})
                2'b10:   r_oq_cnt <= r_oq_cnt + 2'd1;
                2'b01:   r_oq_cnt <= r_oq_cnt - 2'd1;
                default: r_oq_cnt <= r_oq_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wp] <= n_side;
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the swept box side test
// Drives box pairs through the push/full queue, predicts the contact side of
// every beat with a behavioural model and checks each popped result in order.
// ----------------------------------------------------------------------------
module tb;
    import sbcs_pkg::*;

    localparam int N_RANDOM    = 2000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;
    localparam int N_DIRECTED  = 12;

    typedef struct {
        t_coord al, ar, at, ab, bl, br, bt, bb, asx, asy, bsx, bsy;
    } t_pair;

    typedef struct {
        t_kind          kind;
        logic           hi;
        longint         depth;
        longint         t_in;
        longint         t_out;
    } t_axis;

    logic   clk;
    logic   rst_n;
    logic   push;
    logic   full;
    logic   empty;
    logic   pop;
    logic [2:0] side_out;
    t_pair  drv;

    t_side  side_q[$];
    int     n_mismatch;
    int     cycles;
    bit     stim_done;
    bit     hold_pop;

    swept_box_collision_side dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_push(push), .o_full(full),
        .i_a_left(drv.al), .i_a_right(drv.ar), .i_a_top(drv.at), .i_a_bottom(drv.ab),
        .i_b_left(drv.bl), .i_b_right(drv.br), .i_b_top(drv.bt), .i_b_bottom(drv.bb),
        .i_a_step_x(drv.asx), .i_a_step_y(drv.asy),
        .i_b_step_x(drv.bsx), .i_b_step_y(drv.bsy),
        .o_empty(empty), .i_pop(pop), .o_contact_side(side_out)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Truncating divide into Q.16, saturated to about [-2, 2).
    function automatic longint frame_time(longint d, longint v);
        longint q;
        longint hi;
        hi = (64'sd1 <<< (TIME_FRAC_BITS + 1)) - 1;
        q = (d * (64'sd1 <<< TIME_FRAC_BITS)) / v;
        if (q > hi) q = hi;
        if (q < -hi - 1) q = -hi - 1;
        return q;
    endfunction

    function automatic t_axis classify_axis(longint lo_a, longint hi_a, longint lo_b,
                                            longint hi_b, longint v);
        t_axis  r;
        longint de;
        longint dx;
        r = '{KIND_NONE, 1'b0, 0, 0, 0};
        if (v == 0 || (hi_a >= lo_b && lo_a <= hi_b)) begin
            // overlapping or not moving: a depth, or no contact at all
            if (lo_a <= hi_b && lo_a >= lo_b - (hi_a - lo_a)) begin
                r.kind = KIND_STATIC;
                r.hi = !(lo_a <= lo_b);
                r.depth = r.hi ? hi_b - lo_a : hi_a - lo_b;
            end
            return r;
        end
        de = lo_b - hi_a;
        dx = hi_b - lo_a;
        if (v < 0) begin
            longint t;
            t = de; de = dx; dx = t;
        end
        r.kind = KIND_SWEPT;
        r.hi = de < 0;
        r.t_in = frame_time(de, v);
        r.t_out = frame_time(dx, v);
        return r;
    endfunction

    function automatic bit in_frame(longint t_in, longint t_out);
        return t_in < t_out && t_in > 0 && t_in < (64'sd1 <<< TIME_FRAC_BITS);
    endfunction

    function automatic t_side contact_side_of(t_pair p);
        t_axis  ax;
        t_axis  ay;
        t_side  sx;
        t_side  sy;
        longint t_in;
        longint t_out;
        ax = classify_axis(p.al, p.ar, p.bl, p.br, longint'(p.asx) - longint'(p.bsx));
        ay = classify_axis(p.ab, p.at, p.bb, p.bt, longint'(p.asy) - longint'(p.bsy));
        sx = ax.hi ? SIDE_RIGHT : SIDE_LEFT;
        sy = ay.hi ? SIDE_TOP : SIDE_BOTTOM;
        if (ax.kind == KIND_NONE || ay.kind == KIND_NONE) return SIDE_NONE;
        if (ax.kind == KIND_STATIC && ay.kind == KIND_STATIC)
            return (ax.depth <= ay.depth) ? sx : sy;
        if (ay.kind == KIND_STATIC) return in_frame(ax.t_in, ax.t_out) ? sx : SIDE_NONE;
        if (ax.kind == KIND_STATIC) return in_frame(ay.t_in, ay.t_out) ? sy : SIDE_NONE;
        t_in = (ax.t_in > ay.t_in) ? ax.t_in : ay.t_in;
        t_out = (ax.t_out < ay.t_out) ? ax.t_out : ay.t_out;
        if (!in_frame(t_in, t_out)) return SIDE_NONE;
        return (ax.t_in > ay.t_in) ? sx : sy;
    endfunction

    function automatic t_coord rand_coord();
        return t_coord'($urandom);
    endfunction

    // Mostly boxes near one another with small steps so that contacts occur.
    function automatic t_pair rand_pair();
        t_pair  p;
        int     mode;
        int     span;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            p = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord()};
            return p;
        end
        span = (mode == 1) ? 24'h7fffff : 24'h3fff;
        p.al = t_coord'($urandom_range(0, span) - span / 2);
        p.ar = p.al + t_coord'($urandom_range(0, 24'h1fff));
        p.ab = t_coord'($urandom_range(0, span) - span / 2);
        p.at = p.ab + t_coord'($urandom_range(0, 24'h1fff));
        p.bl = p.al + t_coord'($urandom_range(0, 24'h3fff) - 24'h1fff);
        p.br = p.bl + t_coord'($urandom_range(0, 24'h1fff));
        p.bb = p.ab + t_coord'($urandom_range(0, 24'h3fff) - 24'h1fff);
        p.bt = p.bb + t_coord'($urandom_range(0, 24'h1fff));
        p.asx = t_coord'($urandom_range(0, 24'h3fff) - 24'h1fff);
        p.asy = t_coord'($urandom_range(0, 24'h3fff) - 24'h1fff);
        p.bsx = ($urandom_range(0, 3) == 0) ? p.asx : t_coord'($urandom_range(0, 24'hfff));
        p.bsy = ($urandom_range(0, 3) == 0) ? p.asy : t_coord'($urandom_range(0, 24'hfff));
        if (mode == 2) begin
            // inverted edges go through the same comparisons
            p.ar = p.al - t_coord'($urandom_range(1, 24'hff));
            p.bt = p.bb - t_coord'($urandom_range(1, 24'hff));
        end
        return p;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Directed table: side typed in where the outcome is obvious; the other
    // rows take their side from the predictor.
    t_pair  dir_pair[N_DIRECTED];
    t_side  dir_side[N_DIRECTED];
    bit     dir_fixed[N_DIRECTED];

    initial begin
        // overlap, x shallower: A pokes B from the left
        dir_pair[0] = '{0, 256, 1000, 0, 200, 1200, 1000, 0, 0, 0, 0, 0};
        dir_side[0] = SIDE_LEFT; dir_fixed[0] = 1;
        // overlap, A to the right of B
        dir_pair[1] = '{1000, 1256, 1000, 0, 0, 1100, 1000, 0, 0, 0, 0, 0};
        dir_side[1] = SIDE_RIGHT; dir_fixed[1] = 1;
        // far apart, no motion
        dir_pair[2] = '{0, 10, 10, 0, 5000, 5010, 5010, 5000, 0, 0, 0, 0};
        dir_side[2] = SIDE_NONE; dir_fixed[2] = 1;
        // A falls onto B from above (y swept, x static)
        dir_pair[3] = '{0, 256, 600, 400, 0, 256, 300, 0, 0, -256, 0, 0};
        dir_side[3] = SIDE_TOP; dir_fixed[3] = 1;
        // A rises into B from below
        dir_pair[4] = '{0, 256, 256, 0, 0, 256, 600, 400, 0, 256, 0, 0};
        dir_side[4] = SIDE_BOTTOM; dir_fixed[4] = 1;
        // A moves right into B
        dir_pair[5] = '{0, 256, 256, 0, 300, 556, 256, 0, 512, 0, 0, 0};
        dir_side[5] = SIDE_LEFT; dir_fixed[5] = 1;
        // too slow to arrive this frame
        dir_pair[6] = '{0, 256, 256, 0, 2000, 2256, 256, 0, 1, 0, 0, 0};
        dir_side[6] = SIDE_NONE; dir_fixed[6] = 1;
        // extremes of every field
        dir_pair[7] = '{24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000,
                        24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000,
                        24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff};
        dir_fixed[7] = 0;
        dir_pair[8] = '{24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff,
                        24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff,
                        24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000};
        dir_fixed[8] = 0;
        // both swept diagonally; then a tiny step that saturates the quotient
        dir_pair[9] = '{0, 256, 256, 0, 300, 556, 556, 300, 400, 400, 0, 0};
        dir_fixed[9] = 0;
        dir_pair[10] = '{24'h800000, 24'h800100, 0, 24'h800000, 24'h7fff00, 24'h7fffff,
                         10, 0, 1, 0, 0, 0};
        dir_fixed[10] = 0;
        // inverted box
        dir_pair[11] = '{256, 0, 0, 256, 100, 50, 300, 0, -10, 0, 0, 0};
        dir_fixed[11] = 0;
        for (int i = 0; i < N_DIRECTED; i++)
            if (!dir_fixed[i]) dir_side[i] = contact_side_of(dir_pair[i]);
    end

    // Sender: offer a beat, hold it until accepted, then maybe idle.
    task automatic send_beat(t_pair p, t_side s);
        int g;
        drv <= p;
        push <= 1'b1;
        do @(posedge clk); while (full);
        side_q.push_back(s);
        g = gap_len();
        @(negedge clk);
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    initial begin
        t_pair p;
        rst_n = 1'b0;
        push = 1'b0;
        drv = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        stim_done = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int i = 0; i < N_DIRECTED; i++) send_beat(dir_pair[i], dir_side[i]);
        for (int i = 0; i < N_RANDOM; i++) begin
            p = rand_pair();
            send_beat(p, contact_side_of(p));
        end
        push <= 1'b0;
        stim_done = 1;
    end

    // Receiver back-pressure; one long hold-off forces the block to fill up.
    initial begin
        hold_pop = 0;
        wait (rst_n);
        repeat (100) @(posedge clk);
        hold_pop = 1;
        repeat (200) @(posedge clk);
        hold_pop = 0;
    end

    initial begin
        int g;
        pop = 1'b0;
        forever begin
            @(negedge clk);
            g = gap_len();
            if (g > 0) begin
                pop <= 1'b0;
                repeat (g) @(negedge clk);
            end
            pop <= !hold_pop;
        end
    end

    // Check every popped result against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            if (side_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result side=%0d", side_out);
            end else begin
                t_side s;
                s = side_q.pop_front();
                if (side_out !== s) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("side mismatch: expected %0d got %0d", s, side_out);
                end
            end
        end
    end

    initial begin
        n_mismatch = 0;
        cycles = 0;
        fork
            forever begin
                @(posedge clk);
                cycles++;
                if (cycles > CYCLE_LIMIT) begin
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        join_none
        wait (stim_done);
        wait (side_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_mismatch == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
